>>> sv/hv3_pkg.sv
// Shared constants for the 3-D hypervolume sweep block.
// No dependencies; imported by the top level.
`default_nettype none
package hv3_pkg;
  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_COORD_BITS = 16;
  localparam int VOL_W  = 48;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_EN  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;

  // error flag bit positions
  localparam int ERR_RANGE_BIT = 0;
  localparam int ERR_OVER_BIT  = 1;
endpackage
`default_nettype wire

>>> sv/hv3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/hv3_mul.sv
// Shared registered multiplier used for every area and volume product.
// No dependencies.
`default_nettype none
module hv3_mul #(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end
endmodule
`default_nettype wire

>>> sv/hypervolume_3d_sweep.sv
// Top level of the 3-D hypervolume sweep: sequencer, point store, front store.
// Depends on hv3_pkg, hv3_ram and hv3_mul.
//
// Points load one per cycle (in_stall low) until the point marked last. The
// block then stalls its input while it optionally insertion-sorts the stored
// points by z (n^2/2 compare/move steps worst case, bound by the single read
// port of the point RAM) and sweeps along z. Each sweep point in range takes
// one scan of the front to find its place; unless it is dominated, one copy
// pass then rebuilds the front into the other bank of the front RAM, a pruned
// entry costing a multiply on the one shared multiplier that every area product
// goes through. One result (volume, status) follows; the next set may load
// while it waits. No clearing pass is needed after reset.
`default_nettype none
module hypervolume_3d_sweep
  import hv3_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_coord_x,
  input  wire logic [COORD_BITS-1:0] in_coord_y,
  input  wire logic [COORD_BITS-1:0] in_coord_z,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VOL_W-1:0]           out_volume,
  output logic [STAT_W-1:0]          out_status,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [COORD_BITS-1:0] cfg_wdata
);
  localparam int CW  = COORD_BITS;
  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KW  = $clog2(MAX_POINTS + 2);
  localparam int PW  = 3 * CW;
  localparam int SW  = ((PW > VOL_W) ? PW : VOL_W) + 1;
  localparam int FR_DEPTH = 2 * (1 << IW);
  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
  localparam logic [KW-1:0] MAXK = KW'(MAX_POINTS);

  typedef enum logic [4:0] {
    S_LOAD, SO_RD, SO_TMP, SO_CRD, SO_CMP,
    SW_START, SW_RD, SW_PT, F1_RD, F1_CMP, F1_CHK, VOL_ACC,
    F2_RD, F2_CMP, F2_SUB, F2_ADD, F2_ADD2, FIN_MUL, FIN_ACC, S_OUT
  } state_t;

  function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  state_t state_r, state_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [KW-1:0] ins_r, ins_nxt, wp_r, wp_nxt, fcnt_r, fcnt_nxt;
  logic [1:0] err_r, err_nxt;
  logic bank_r, bank_nxt, ins_done_r, ins_done_nxt;
  logic [PW-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt, qy_r, qy_nxt;
  logic [CW-1:0] lastx_r, lastx_nxt, prevx_r, prevx_nxt, prevz_r, prevz_nxt;
  logic [2*CW-1:0] area_r, area_nxt;
  logic [VOL_W-1:0] vol_r, vol_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [VOL_W-1:0] out_vol_r, out_vol_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [CW-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic sort_en_r;

  logic pt_we;
  logic [IW-1:0] pt_waddr, pt_raddr;
  logic [PW-1:0] pt_wdata, pt_rdata;
  logic fr_we;
  logic [IW:0] fr_waddr, fr_raddr;
  logic [2*CW-1:0] fr_wdata, fr_rdata;
  logic [2*CW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic [SW-1:0] vsum;
  logic [KW-1:0] km1, jm1;
  logic [CW-1:0] rx, ry, rz, fx, fy, tz;
  logic in_acc, out_free;

  hv3_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  hv3_ram #(.WIDTH(2*CW), .DEPTH(FR_DEPTH)) u_fr_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  hv3_mul #(.A_W(2*CW), .B_W(CW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p)
  );

  assign in_stall   = (state_r != S_LOAD);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_volume = out_vol_r;
  assign out_status = out_stat_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign rx  = pt_rdata[CW-1:0];
  assign ry  = pt_rdata[2*CW-1:CW];
  assign rz  = pt_rdata[3*CW-1:2*CW];
  assign tz  = tmp_r[3*CW-1:2*CW];
  assign fx  = fr_rdata[CW-1:0];
  assign fy  = fr_rdata[2*CW-1:CW];
  assign km1 = k_r - 1'b1;
  assign jm1 = j_r - 1'b1;
  assign vsum = SW'(vol_r) + SW'(mul_p);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    ins_nxt = ins_r; wp_nxt = wp_r; fcnt_nxt = fcnt_r;
    err_nxt = err_r; bank_nxt = bank_r; ins_done_nxt = ins_done_r;
    tmp_nxt = tmp_r; px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r; qy_nxt = qy_r;
    lastx_nxt = lastx_r; prevx_nxt = prevx_r; prevz_nxt = prevz_r;
    area_nxt = area_r; vol_nxt = vol_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_vol_nxt = out_vol_r; out_stat_nxt = out_stat_r;
    pt_we = 1'b0; pt_waddr = cnt_r[IW-1:0];
    pt_wdata = {in_coord_z, in_coord_y, in_coord_x};
    pt_raddr = i_r[IW-1:0];
    fr_we = 1'b0; fr_waddr = {~bank_r, wp_r[IW-1:0]};
    fr_wdata = {py_r, px_r};
    fr_raddr = {bank_r, km1[IW-1:0]};
    mul_a = '0; mul_b = '0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < MAXK) begin
            pt_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            err_nxt[ERR_OVER_BIT] = 1'b1;
          end
          if (in_last) begin
            if (sort_en_r && (cnt_nxt > KW'(1))) begin
              i_nxt     = KW'(1);
              state_nxt = SO_RD;
            end else begin
              state_nxt = SW_START;
            end
          end
        end
      end
      SO_RD: begin
        state_nxt = SO_TMP;
      end
      SO_TMP: begin
        tmp_nxt   = pt_rdata;
        j_nxt     = i_r;
        state_nxt = SO_CRD;
      end
      SO_CRD: begin
        pt_raddr = jm1[IW-1:0];
        if (j_r == '0) begin
          pt_we = 1'b1; pt_waddr = '0; pt_wdata = tmp_r;
          i_nxt = i_r + 1'b1;
          state_nxt = (i_nxt < cnt_r) ? SO_RD : SW_START;
        end else begin
          state_nxt = SO_CMP;
        end
      end
      SO_CMP: begin
        pt_we    = 1'b1;
        pt_waddr = j_r[IW-1:0];
        if (rz > tz) begin
          // shift the larger entry up and keep walking down
          pt_wdata  = pt_rdata;
          j_nxt     = jm1;
          state_nxt = SO_CRD;
        end else begin
          pt_wdata  = tmp_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_nxt < cnt_r) ? SO_RD : SW_START;
        end
      end
      SW_START: begin
        i_nxt = '0; fcnt_nxt = '0; area_nxt = '0; vol_nxt = '0;
        prevz_nxt = '0; bank_nxt = 1'b0;
        state_nxt = SW_RD;
      end
      SW_RD: begin
        state_nxt = (i_r == cnt_r) ? FIN_MUL : SW_PT;
      end
      SW_PT: begin
        px_nxt = rx; py_nxt = ry; pz_nxt = rz;
        if ((rx >= ref_x_r) || (ry >= ref_y_r) || (rz >= ref_z_r)) begin
          err_nxt[ERR_RANGE_BIT] = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = SW_RD;
        end else begin
          k_nxt     = KW'(1);
          state_nxt = F1_RD;
        end
      end
      F1_RD: begin
        if (k_r > fcnt_r) begin
          ins_nxt   = k_r;
          qy_nxt    = ref_y_r;
          state_nxt = F1_CHK;
        end else begin
          state_nxt = F1_CMP;
        end
      end
      F1_CMP: begin
        if (fx >= px_r) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = F1_RD;
        end else begin
          ins_nxt   = k_r;
          qy_nxt    = fy;
          state_nxt = F1_CHK;
        end
      end
      F1_CHK: begin
        if (qy_r <= py_r) begin
          // dominated: drop
          i_nxt     = i_r + 1'b1;
          state_nxt = SW_RD;
        end else begin
          mul_a     = area_r;
          mul_b     = adiff(prevz_r, pz_r);
          prevz_nxt = pz_r;
          state_nxt = VOL_ACC;
        end
      end
      VOL_ACC: begin
        vol_nxt = (vsum > SW'(VOL_MAX)) ? VOL_MAX : vsum[VOL_W-1:0];
        k_nxt = KW'(1); wp_nxt = '0; ins_done_nxt = 1'b0;
        lastx_nxt = ref_x_r; prevx_nxt = ref_x_r;
        state_nxt = F2_RD;
      end
      F2_RD: begin
        if (k_r > fcnt_r) begin
          if (!ins_done_r) begin
            fr_we  = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
          state_nxt = F2_ADD;
        end else begin
          state_nxt = F2_CMP;
        end
      end
      F2_CMP: begin
        if ((k_r < ins_r) && (fy >= py_r)) begin
          // covered entry: take its strip out of the area
          mul_a     = (2*CW)'(adiff(fx, prevx_r));
          mul_b     = adiff(fy, qy_r);
          prevx_nxt = fx;
          state_nxt = F2_SUB;
        end else if ((k_r == ins_r) && !ins_done_r) begin
          fr_we        = 1'b1;
          wp_nxt       = wp_r + 1'b1;
          ins_done_nxt = 1'b1;
          state_nxt    = F2_RD;
        end else begin
          fr_we    = 1'b1;
          fr_wdata = fr_rdata;
          wp_nxt   = wp_r + 1'b1;
          if (k_r < ins_r) begin
            lastx_nxt = fx;
          end
          prevx_nxt = fx;
          k_nxt     = k_r + 1'b1;
          state_nxt = F2_RD;
        end
      end
      F2_SUB: begin
        area_nxt  = area_r - mul_p[2*CW-1:0];
        k_nxt     = k_r + 1'b1;
        state_nxt = F2_RD;
      end
      F2_ADD: begin
        mul_a     = (2*CW)'(adiff(px_r, lastx_r));
        mul_b     = adiff(py_r, qy_r);
        state_nxt = F2_ADD2;
      end
      F2_ADD2: begin
        area_nxt  = area_r + mul_p[2*CW-1:0];
        fcnt_nxt  = wp_r;
        bank_nxt  = ~bank_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = SW_RD;
      end
      FIN_MUL: begin
        mul_a     = area_r;
        mul_b     = adiff(prevz_r, ref_z_r);
        state_nxt = FIN_ACC;
      end
      FIN_ACC: begin
        vol_nxt   = (vsum > SW'(VOL_MAX)) ? VOL_MAX : vsum[VOL_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vol_nxt   = vol_r;
          if (err_r[ERR_OVER_BIT]) begin
            out_stat_nxt = STAT_OVER;
          end else if (err_r[ERR_RANGE_BIT]) begin
            out_stat_nxt = STAT_RANGE;
          end else begin
            out_stat_nxt = STAT_OK;
          end
          cnt_nxt   = '0;
          err_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      err_r       <= '0;
      fcnt_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ref_x_r     <= '1;
      ref_y_r     <= '1;
      ref_z_r     <= '1;
      sort_en_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      fcnt_r      <= fcnt_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REF_X:   ref_x_r   <= cfg_wdata;
          CFG_REF_Y:   ref_y_r   <= cfg_wdata;
          CFG_REF_Z:   ref_z_r   <= cfg_wdata;
          CFG_SORT_EN: sort_en_r <= cfg_wdata[0];
          default:     ;
        endcase
      end
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; ins_r <= ins_nxt; wp_r <= wp_nxt;
    ins_done_r <= ins_done_nxt; tmp_r <= tmp_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt; qy_r <= qy_nxt;
    lastx_r <= lastx_nxt; prevx_r <= prevx_nxt; prevz_r <= prevz_nxt;
    area_r <= area_nxt; vol_r <= vol_nxt;
    out_vol_r <= out_vol_nxt; out_stat_r <= out_stat_nxt;
  end

`ifndef ASSERT_OFF
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r <= MAXK))
    else $error("front count beyond store depth");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_stat_r == STAT_OK || out_stat_r == STAT_RANGE ||
                            out_stat_r == STAT_OVER))
    else $error("bad status code");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (cnt_r <= MAXK))
    else $error("point count beyond store depth");
`endif
endmodule
`default_nettype wire

>>> sim/tb_hypervolume_3d_sweep.sv
// Self-checking testbench for hypervolume_3d_sweep: point sets in, volume and status out.
// Depends on hv3_pkg and the block's RTL; carries its own sweep predictor.
`timescale 1ns / 100ps
module tb_hypervolume_3d_sweep;
  import hv3_pkg::*;

  localparam int NPTS     = DEF_MAX_POINTS;
  localparam int ITEMS    = 1750;
  localparam int IDLE_MAX = 600000;
  localparam logic [63:0] VOL_CAP = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
    logic        fixed;   // expectation typed in the table
    logic [47:0] vol;
    logic [1:0]  stat;
  } point_t;

  typedef struct {
    logic [47:0] vol;
    logic [1:0]  stat;
  } hv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_coord_x = '0;
  logic [15:0] in_coord_y = '0;
  logic [15:0] in_coord_z = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VOL_W-1:0] out_volume;
  logic [STAT_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_REF_X;
  logic [15:0] cfg_wdata = '0;

  hypervolume_3d_sweep i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_volume(out_volume), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: register copies and the points of the set being loaded.
  logic [15:0] ref_x_q = 16'hFFFF, ref_y_q = 16'hFFFF, ref_z_q = 16'hFFFF;
  logic        sort_en_q = 1'b1;
  logic [15:0] set_x[NPTS], set_y[NPTS], set_z[NPTS];
  int unsigned set_cnt = 0;
  logic [1:0]  set_err = '0;

  point_t     stim_q[$];
  hv_result_t volume_q[$];
  int  fails = 0;
  int  pushed = 0;
  bit  calm = 0;
  int  idle_cycles = 0;

  function automatic longint unsigned coord_gap(int unsigned a, int unsigned b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add);
    return (add > VOL_CAP - acc) ? VOL_CAP : acc + add;
  endfunction

  // Sweep the loaded set along z and return volume and status.
  function automatic hv_result_t sweep_set();
    int unsigned px[NPTS], py[NPTS], pz[NPTS];
    int unsigned fx[NPTS+2], fy[NPTS+2];
    int unsigned n, ins, j, qy, removed, cnt, tx, ty, tz, k, zprev;
    logic [63:0] area, vol;
    hv_result_t r;
    for (int i = 0; i < set_cnt; i++) begin
      px[i] = set_x[i]; py[i] = set_y[i]; pz[i] = set_z[i];
    end
    if (sort_en_q) begin
      for (int i = 1; i < set_cnt; i++) begin
        tx = px[i]; ty = py[i]; tz = pz[i];
        j = i;
        while (j > 0 && pz[j-1] > tz) begin
          px[j] = px[j-1]; py[j] = py[j-1]; pz[j] = pz[j-1];
          j--;
        end
        px[j] = tx; py[j] = ty; pz[j] = tz;
      end
    end
    cnt = 0; area = 0; vol = 0; zprev = 0;
    fx[0] = ref_x_q; fy[0] = 0;
    for (int i = 0; i < set_cnt; i++) begin
      if (px[i] >= ref_x_q || py[i] >= ref_y_q || pz[i] >= ref_z_q) begin
        set_err[ERR_RANGE_BIT] = 1'b1;
        continue;
      end
      n = cnt;
      ins = 1;
      while (ins <= n && fx[ins] >= px[i]) ins++;
      qy = (ins > n) ? ref_y_q : fy[ins];
      if (qy <= py[i]) continue;   // dominated: drop
      vol = sat_add(vol, area * coord_gap(zprev, pz[i]));
      zprev = pz[i];
      j = ins - 1;
      while (j >= 1 && fy[j] >= py[i]) begin
        area -= coord_gap(fx[j], fx[j-1]) * coord_gap(fy[j], qy);
        j--;
      end
      area += coord_gap(px[i], fx[j]) * coord_gap(py[i], qy);
      removed = ins - 1 - j;
      // shift the tail [ins..n] to start at j+2
      if (j + 2 > ins) begin
        for (k = n + 1; k >= ins + 1; k--) begin
          fx[k] = fx[k-1]; fy[k] = fy[k-1];
        end
      end else if (j + 2 < ins) begin
        for (k = 0; k + ins <= n; k++) begin
          fx[j+2+k] = fx[ins+k]; fy[j+2+k] = fy[ins+k];
        end
      end
      fx[j+1] = px[i]; fy[j+1] = py[i];
      cnt = n - removed + 1;
    end
    vol = sat_add(vol, area * coord_gap(zprev, ref_z_q));
    r.vol = vol[47:0];
    r.stat = set_err[ERR_OVER_BIT] ? STAT_OVER :
             set_err[ERR_RANGE_BIT] ? STAT_RANGE : STAT_OK;
    return r;
  endfunction

  task automatic take_point(point_t p);
    hv_result_t r;
    if (set_cnt < NPTS) begin
      set_x[set_cnt] = p.x; set_y[set_cnt] = p.y; set_z[set_cnt] = p.z;
      set_cnt++;
    end else begin
      set_err[ERR_OVER_BIT] = 1'b1;
    end
    if (p.last) begin
      r = sweep_set();
      if (p.fixed) begin
        r.vol = p.vol; r.stat = p.stat;
      end
      volume_q.insert(volume_q.size(), r);
      set_cnt = 0;
      set_err = '0;
    end
  endtask

  // Input side: hold a stalled transfer, otherwise drive the next point or idle.
  int in_gap = 0;
  point_t cur;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) take_point(cur);
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0 && !calm && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur = stim_q[0];
          stim_q.delete(0);
          in_coord_x <= cur.x;
          in_coord_y <= cur.y;
          in_coord_z <= cur.z;
          in_last <= cur.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transfer, stall in random bursts.
  int out_gap = 0;
  hv_result_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (volume_q.size() == 0) begin
          $error("unexpected result volume=%0d status=%0d", out_volume, out_status);
          fails++;
        end else begin
          want = volume_q[0];
          volume_q.delete(0);
          if (out_volume !== want.vol) begin
            $error("volume: expected %0d, got %0d", want.vol, out_volume);
            fails++;
          end
          if (out_status !== want.stat) begin
            $error("status: expected %0d, got %0d", want.stat, out_status);
            fails++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REF_X:   ref_x_q = val;
      CFG_REF_Y:   ref_y_q = val;
      CFG_REF_Z:   ref_z_q = val;
      CFG_SORT_EN: sort_en_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until the block has drained, then leave room for trailing work.
  task automatic drain();
    while (stim_q.size() > 0 || volume_q.size() > 0 || in_valid) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [15:0] pick(int mode, logic [15:0] r);
    int unsigned v;
    case (mode)
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 15);
      default: begin
        if ($urandom_range(0, 1)) v = $urandom_range(0, 65535);
        else v = int'(r) + 2 - $urandom_range(0, 4);
      end
    endcase
    return v[15:0];
  endfunction

  // Queue one set. Mode 0 full range, 1 tiny range with ties,
  // 2 near the reference, 3 staircase for a wide front.
  task automatic queue_set(int n, int mode, bit zsorted);
    point_t p;
    logic [15:0] zs[$];
    for (int i = 0; i < n; i++)
      zs.insert(zs.size(),
                mode == 3 ? 16'($urandom_range(0, 60000)) : pick(mode, ref_z_q));
    if (zsorted) zs.sort();
    for (int i = 0; i < n; i++) begin
      if (mode == 3) begin
        p.x = 16'($urandom_range(0, 60000));
        p.y = 16'(60000 - int'(p.x) + $urandom_range(0, 400));
      end else begin
        p.x = pick(mode, ref_x_q);
        p.y = pick(mode, ref_y_q);
      end
      p.z = zs[i];
      p.last = (i == n - 1);
      p.fixed = 1'b0; p.vol = '0; p.stat = STAT_OK;
      stim_q.insert(stim_q.size(), p);
      pushed++;
    end
  endtask

  point_t directed[] = '{
    '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 48'd281462092005375, STAT_OK},
    '{16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1, 48'd0, STAT_RANGE},
    '{16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b1, 48'd0, STAT_RANGE},
    '{16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 48'd0, STAT_RANGE},
    '{16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b1, 1'b1, 48'd1, STAT_OK},
    '{16'd100, 16'd200, 16'd300, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd200, 16'd100, 16'd50, 1'b1, 1'b0, 48'd0, STAT_OK},
    '{16'd10, 16'd10, 16'd10, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd20, 16'd20, 16'd20, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd10, 16'd10, 16'd10, 1'b1, 1'b0, 48'd0, STAT_OK},
    '{16'd100, 16'd5, 16'd900, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd5, 16'd100, 16'd10, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd50, 16'd50, 16'd400, 1'b1, 1'b0, 48'd0, STAT_OK},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 48'd0, STAT_OK},
    '{16'd1, 16'd2, 16'd3, 1'b1, 1'b0, 48'd0, STAT_OK}
  };

  initial begin
    int sets;
    int mode;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      stim_q.insert(stim_q.size(), directed[i]);
      pushed++;
    end
    drain();

    // large sets: full store, overflow, staircase; sort off: presorted full store
    queue_set(NPTS, 0, 0);
    queue_set(NPTS + 3, 0, 0);
    queue_set(64, 3, 0);
    drain();
    cfg_write(CFG_SORT_EN, 16'd0);
    cfg_we <= 1'b0;
    queue_set(NPTS, 0, 1);
    queue_set(20, 0, 0);
    drain();

    sets = 0;
    while (pushed < ITEMS) begin
      if (sets % 6 == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0: cfg_write(CFG_REF_X, 16'hFFFF);
          1: cfg_write(CFG_REF_X, 16'd0);
          default: cfg_write(CFG_REF_X, 16'($urandom_range(0, 65535)));
        endcase
        case ($urandom_range(0, 4))
          0: cfg_write(CFG_REF_Y, 16'hFFFF);
          1: cfg_write(CFG_REF_Y, 16'd0);
          default: cfg_write(CFG_REF_Y, 16'($urandom_range(0, 65535)));
        endcase
        case ($urandom_range(0, 4))
          0: cfg_write(CFG_REF_Z, 16'hFFFF);
          1: cfg_write(CFG_REF_Z, 16'd0);
          default: cfg_write(CFG_REF_Z, 16'($urandom_range(0, 65535)));
        endcase
        cfg_write(CFG_SORT_EN, 16'($urandom_range(0, 1)));
        cfg_we <= 1'b0;
      end
      if (ITEMS - pushed < 150) calm = 1;
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
      queue_set($urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12),
                mode, sort_en_q ? $urandom_range(0, 1) : $urandom_range(0, 3) != 0);
      sets++;
    end
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && volume_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
